// ===== rtl/core/ltkat_pkg.sv =====
`default_nettype none

package ltkat_pkg;

	localparam int MAG_W  = 32;
	localparam int RANK_W = 6;
	localparam int KEEP_W = 7;

	localparam logic              OP_OFFER   = 1'b0;
	localparam logic              OP_DUMP    = 1'b1;
	localparam logic [KEEP_W-1:0] KEEP_RESET = 7'd16;
	localparam logic [15:0]       STEP_MAX   = 16'hFFFF;

	// one offered item or dump request
	typedef struct packed {
		logic               opcode;
		logic signed [15:0] sample_real;
		logic signed [15:0] sample_imag;
		logic [63:0]        time_bits;
		logic [7:0]         antenna_first;
		logic [7:0]         antenna_second;
		logic [12:0]        channel_index;
		logic [1:0]         pol_index;
	} in_t;

	// one dump result
	typedef struct packed {
		logic               entry_valid;
		logic [RANK_W-1:0]  rank;
		logic [MAG_W-1:0]   magnitude_sq;
		logic signed [15:0] out_real;
		logic signed [15:0] out_imag;
		logic [15:0]        out_timestep;
		logic [7:0]         out_antenna_first;
		logic [7:0]         out_antenna_second;
		logic [12:0]        out_channel;
		logic [1:0]         out_pol;
		logic               last;
	} out_t;

	// one held list entry
	typedef struct packed {
		logic [MAG_W-1:0]   mag;
		logic signed [15:0] re;
		logic signed [15:0] im;
		logic [15:0]        step;
		logic [7:0]         ant_a;
		logic [7:0]         ant_b;
		logic [12:0]        chan;
		logic [1:0]         pol;
	} entry_t;

	// chain-wide control
	typedef struct packed {
		logic insert;  // write new entry at its sorted place, shift the tail up
		logic rotate;  // move every held entry one place toward the head, the head entry to the tail
	} ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/lowest_k_amplitude_tracker.sv =====
`default_nettype none

// Channel     | Signals                        | Direction | Transfer when
// ------------+--------------------------------+-----------+----------------------
// command     | start, busy, cmd               | in        | start && !busy
// result      | result_strobe, result          | out       | result_strobe (1 cycle)
// keep config | keep_wr_en, keep_wr_data       | in        | keep_wr_en
//
// Offers: one per cycle, back to back, while not busy. Products are registered on
//   transfer; the sorted insert into the cell chain lands on the next edge.
// Dump: busy while the chain rotates once through the held entries; results
//   follow in the next cycle, smallest first.
// Reset clears count, step counter and time tracking; entries stay unknown
//   until written. The receiver cannot stall: each result shows for one cycle.

module lowest_k_amplitude_tracker #(
	parameter int MAX_KEEP = 64
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               start,
	output logic                              busy,
	input  ltkat_pkg::in_t                    cmd,
	input  wire                               keep_wr_en,
	input  wire [ltkat_pkg::KEEP_W-1:0]       keep_wr_data,
	output logic                              result_strobe,
	output ltkat_pkg::out_t                   result
);

	localparam int CW = $clog2(MAX_KEEP + 1);
	localparam int EW = ((CW > ltkat_pkg::KEEP_W) ? CW : ltkat_pkg::KEEP_W) + 1;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_DUMP = 2'b10
	} state_t;

	state_t                         state_q;
	logic [ltkat_pkg::KEEP_W-1:0]   keep_q;
	logic [CW-1:0]                  count_q;
	logic [CW-1:0]                  k_q;
	logic [15:0]                    step_q;
	logic [15:0]                    step_next;
	logic [63:0]                    prev_time_q;
	logic                           seen_q;

	// offer stage: squared parts and tags
	logic                           valid_s1;
	logic [30:0]                    pre_s1;
	logic [30:0]                    pim_s1;
	ltkat_pkg::entry_t              tag_s1;

	ltkat_pkg::out_t                res_q;
	logic                           strobe_q;

	logic                           xfer;
	logic                           offer_xfer;
	logic                           dump_xfer;
	logic signed [31:0]             sq_re;
	logic signed [31:0]             sq_im;
	logic [ltkat_pkg::MAG_W-1:0]    mag;
	logic                           mag_zero;
	logic [CW-1:0]                  keep_eff;
	logic                           dup;
	logic                           ge_any;
	logic                           admit;
	logic                           dump_last;
	ltkat_pkg::entry_t              new_entry;
	ltkat_pkg::ctrl_t               ctrl;

	ltkat_pkg::entry_t              entry_w [MAX_KEEP];
	logic [MAX_KEEP-1:0]            lt_w;
	logic [MAX_KEEP-1:0]            eq_w;
	logic [MAX_KEEP-1:0]            ge_w;

	assign busy       = state_q == ST_DUMP;
	assign xfer       = start && !busy;
	assign offer_xfer = xfer && (cmd.opcode == ltkat_pkg::OP_OFFER);
	assign dump_xfer  = xfer && (cmd.opcode == ltkat_pkg::OP_DUMP);

	// ---- time-step tracking, done at transfer so the entry gets the new step
	always_comb begin
		step_next = step_q;
		if (seen_q && (cmd.time_bits != prev_time_q) && (step_q != ltkat_pkg::STEP_MAX)) begin
			step_next = step_q + 16'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			prev_time_q <= '0;
			seen_q      <= 1'b0;
		end else if (offer_xfer) begin
			step_q      <= step_next;
			prev_time_q <= cmd.time_bits;
			seen_q      <= 1'b1;
		end
	end

	// ---- keep register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_q <= ltkat_pkg::KEEP_RESET;
		end else if (keep_wr_en) begin
			keep_q <= keep_wr_data;
		end
	end

	assign keep_eff = (EW'(keep_q) > EW'(MAX_KEEP)) ? CW'(MAX_KEEP) : CW'(keep_q);

	// ---- squaring, registered before the sum
	assign sq_re = cmd.sample_real * cmd.sample_real;
	assign sq_im = cmd.sample_imag * cmd.sample_imag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= offer_xfer;
		end
	end

	always_ff @(posedge clk) begin
		if (offer_xfer) begin
			pre_s1        <= sq_re[30:0];
			pim_s1        <= sq_im[30:0];
			tag_s1.mag    <= '0;
			tag_s1.re     <= cmd.sample_real;
			tag_s1.im     <= cmd.sample_imag;
			tag_s1.step   <= step_next;
			tag_s1.ant_a  <= cmd.antenna_first;
			tag_s1.ant_b  <= cmd.antenna_second;
			tag_s1.chan   <= cmd.channel_index;
			tag_s1.pol    <= cmd.pol_index;
		end
	end

	assign mag      = {1'b0, pre_s1} + {1'b0, pim_s1};
	assign mag_zero = mag == '0;

	always_comb begin
		new_entry     = tag_s1;
		new_entry.mag = mag;
	end

	// ---- insert decision from the per-cell compares
	assign dup    = |eq_w;
	assign ge_any = |ge_w;
	assign admit  = valid_s1 && !mag_zero && !dup && ((count_q < keep_eff) || ge_any);

	always_comb begin
		ctrl.insert = admit;
		ctrl.rotate = busy && (count_q != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (valid_s1 && !mag_zero) begin
			if (admit) begin
				// full list: the top entry already fell off the end
				if (count_q < CW'(MAX_KEEP)) begin
					if (count_q + 1'b1 <= keep_eff) begin
						count_q <= count_q + 1'b1;
					end
				end
			end else if (count_q > keep_eff) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// ---- cell chain
	for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
		ltkat_pkg::entry_t prev_e;
		ltkat_pkg::entry_t next_e;
		logic              prev_l;

		if (i == 0) begin : g_head
			assign prev_e = new_entry;
			assign prev_l = 1'b1;
		end else begin : g_body
			assign prev_e = entry_w[i-1];
			assign prev_l = lt_w[i-1];
		end

		if (i == MAX_KEEP - 1) begin : g_end
			assign next_e = entry_w[i];
		end else begin : g_mid
			assign next_e = entry_w[i+1];
		end

		ltkat_cell #(
			.CW  (CW),
			.IDX (i)
		) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.count      (count_q),
			.new_entry  (new_entry),
			.prev_entry (prev_e),
			.prev_lt    (prev_l),
			.next_entry (next_e),
			.head_entry (entry_w[0]),
			.entry      (entry_w[i]),
			.lt         (lt_w[i]),
			.eq         (eq_w[i]),
			.ge         (ge_w[i])
		);
	end

	// ---- dump sequencer: show the head, rotate, repeat count times (once if empty)
	assign dump_last = (count_q == '0) || (k_q == count_q - 1'b1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			k_q      <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (dump_xfer) begin
						state_q <= ST_DUMP;
						k_q     <= '0;
					end
				end
				ST_DUMP: begin
					strobe_q <= 1'b1;
					if (dump_last) begin
						state_q <= ST_IDLE;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (busy) begin
			if (count_q == '0) begin
				// empty list: one invalid result, all fields zero but last
				res_q.entry_valid        <= 1'b0;
				res_q.rank               <= '0;
				res_q.magnitude_sq       <= '0;
				res_q.out_real           <= '0;
				res_q.out_imag           <= '0;
				res_q.out_timestep       <= '0;
				res_q.out_antenna_first  <= '0;
				res_q.out_antenna_second <= '0;
				res_q.out_channel        <= '0;
				res_q.out_pol            <= '0;
				res_q.last               <= 1'b1;
			end else begin
				res_q.entry_valid        <= 1'b1;
				res_q.rank               <= ltkat_pkg::RANK_W'(k_q);
				res_q.magnitude_sq       <= entry_w[0].mag;
				res_q.out_real           <= entry_w[0].re;
				res_q.out_imag           <= entry_w[0].im;
				res_q.out_timestep       <= entry_w[0].step;
				res_q.out_antenna_first  <= entry_w[0].ant_a;
				res_q.out_antenna_second <= entry_w[0].ant_b;
				res_q.out_channel        <= entry_w[0].chan;
				res_q.out_pol            <= entry_w[0].pol;
				res_q.last               <= dump_last;
			end
		end
	end

	assign result_strobe = strobe_q;
	assign result        = res_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_KEEP))
		else $error("held count above storage depth");

	a_dump_no_insert: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !valid_s1)
		else $error("offer in flight during dump");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && result.last) |-> !busy)
		else $error("dump still running after last result");

	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && !result.entry_valid) |-> result.last)
		else $error("empty-list result not marked last");

	a_dup_not_admitted: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && dup) |=> ($stable(count_q) || (count_q == $past(count_q) - 1'b1)))
		else $error("duplicate magnitude grew the list");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/ltkat_cell.sv =====
`default_nettype none

module ltkat_cell #(
	parameter int CW  = 7,
	parameter int IDX = 0
) (
	input  wire                    clk,
	input  ltkat_pkg::ctrl_t       ctrl,
	input  wire [CW-1:0]           count,
	input  ltkat_pkg::entry_t      new_entry,
	input  ltkat_pkg::entry_t      prev_entry,
	input  wire                    prev_lt,
	input  ltkat_pkg::entry_t      next_entry,
	input  ltkat_pkg::entry_t      head_entry,
	output ltkat_pkg::entry_t      entry,
	output logic                   lt,
	output logic                   eq,
	output logic                   ge
);

	ltkat_pkg::entry_t entry_q;
	logic              occ;
	logic              tail;

	assign occ  = CW'(IDX) < count;
	assign tail = count == CW'(IDX + 1);

	assign lt = occ && (entry_q.mag < new_entry.mag);
	assign eq = occ && (entry_q.mag == new_entry.mag);
	assign ge = occ && !lt;

	assign entry = entry_q;

	// insert: smaller entries stay, the first non-smaller slot takes the new one,
	// everything above moves up by one
	always_ff @(posedge clk) begin
		if (ctrl.insert) begin
			if (!lt) begin
				entry_q <= prev_lt ? new_entry : prev_entry;
			end
		end else if (ctrl.rotate) begin
			entry_q <= tail ? head_entry : next_entry;
		end
	end

endmodule

`default_nettype wire
